>>> sv/fndp_pkg.sv
`default_nettype none

package fndp_pkg;

   localparam int DIVIDER_CHOICES_DEF = 9;

   localparam int PFD_W    = 28;
   localparam int TARGET_W = 33;
   localparam int VCO_W    = 34;
   localparam int DVD_W    = 48;
   localparam int STEP_W   = 6;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   localparam logic [CSR_AW-1:0] CSR_PFD_ADDR = 2'd0;

   localparam logic [TARGET_W-1:0] TARGET_MIN   = 33'd12500000;
   localparam logic [TARGET_W-1:0] TARGET_MAX   = 33'd6400000000;
   localparam logic [VCO_W-1:0]    VCO_MIN      = 34'd3200000000;
   localparam logic [VCO_W-1:0]    VCO_MAX      = 34'd6400000000;
   localparam logic [VCO_W-1:0]    VCO_DLY_EDGE = 34'd4000000000;
   localparam logic [19:0]         FRAC_DEN     = 20'd1000000;
   localparam logic [TARGET_W-1:0] N_MIN_LOW    = 33'd26;
   localparam logic [TARGET_W-1:0] N_MIN_HIGH   = 33'd30;
   localparam logic [TARGET_W-1:0] N_LIMIT      = 33'd524287;

   localparam logic [STEP_W-1:0] STEPS_N    = 6'd33;
   localparam logic [STEP_W-1:0] STEPS_FRAC = 6'd48;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_RANGE    = 3'd1;
   localparam logic [2:0] ST_PFD_UNSET = 3'd2;
   localparam logic [2:0] ST_NO_FIT   = 3'd3;
   localparam logic [2:0] ST_N_OVF    = 3'd4;

   localparam logic [1:0] DLY_LOW  = 2'd1;
   localparam logic [1:0] DLY_HIGH = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DIVIDE,
      S_EVAL,
      S_FINISH,
      S_HOLD
   } state_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        divider_bypass;
      logic [3:0]  divider_code;
      logic [18:0] n_integer;
      logic [19:0] n_numerator;
      logic [1:0]  pfd_delay_select;
   } res_type;

   function automatic logic [3:0] div_code(input logic [3:0] idx);
      logic [3:0] code;
      unique case (idx)
         4'd2:    code = 4'd1;
         4'd3:    code = 4'd3;
         4'd4:    code = 4'd5;
         4'd5:    code = 4'd7;
         4'd6:    code = 4'd9;
         4'd7:    code = 4'd12;
         4'd8:    code = 4'd14;
         default: code = 4'd0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> sv/fndp_if.sv
`default_nettype none

interface fndp_req_if;
   logic        valid;
   logic        ready;
   logic [32:0] target_freq_hz;

   modport source (output valid, output target_freq_hz, input ready);
   modport sink (input valid, input target_freq_hz, output ready);
endinterface

interface fndp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        divider_bypass;
   logic [3:0]  divider_code;
   logic [18:0] n_integer;
   logic [19:0] n_numerator;
   logic [1:0]  pfd_delay_select;

   modport source (output valid, output status, output divider_bypass, output divider_code,
                   output n_integer, output n_numerator, output pfd_delay_select,
                   input ready);
   modport sink (input valid, input status, input divider_bypass, input divider_code,
                 input n_integer, input n_numerator, input pfd_delay_select,
                 output ready);
endinterface

`default_nettype wire

>>> sv/fractional_n_divider_planner.sv
// The longest plan tries two in-range dividers, each with a 33-step quotient, plus a
//   48-step fraction.
// One item at a time: the input port opens only when idle, and the shared restoring divider
//   (one bit a cycle) works on one plan's quotients and fraction until its result is out.
// A finished result sits in the output register while the next beat is accepted.
// Reset: synchronous, active high; clears the sequencer, the output valid and pfd to zero.
`default_nettype none

module fractional_n_divider_planner
   import fndp_pkg::*;
#(
   parameter int DIVIDER_CHOICES = DIVIDER_CHOICES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   fndp_req_if.sink               req_bus,
   fndp_rsp_if.source             rsp_bus,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready
);

   localparam int DivCount = (DIVIDER_CHOICES < 1) ? 1 :
                             (DIVIDER_CHOICES > 9) ? 9 : DIVIDER_CHOICES;
   localparam int IW = $clog2(DivCount + 1);

   state_type state_ff, state_in;

   logic [PFD_W-1:0]  pfd_ff, pfd_in;
   logic [VCO_W-1:0]  vco_ff, vco_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [PFD_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              frac_ff, frac_in;
   res_type           res_ff, res_in;
   res_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic              req_take;
   logic              csr_wr;
   logic              bad_range;
   logic              scan_end;
   logic [PFD_W:0]    trial;
   logic [PFD_W:0]    diff;
   logic              ge;
   logic [TARGET_W-1:0] n_quo;
   logic [TARGET_W-1:0] n_min;
   logic              low_vco;
   logic [DVD_W-1:0]  prod;

   assign pready   = 1'b1;
   assign csr_wr   = psel && penable && pwrite && (paddr == CSR_PFD_ADDR);
   assign prdata   = (paddr == CSR_PFD_ADDR) ? CSR_DW'(pfd_ff) : '0;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take = req_bus.valid && req_bus.ready;

   assign bad_range = (vco_ff[TARGET_W-1:0] < TARGET_MIN) || (vco_ff > VCO_W'(TARGET_MAX));
   // vco only grows with the divider, so once past the top no later divider fits
   assign scan_end  = (idx_ff == IW'(DivCount)) || (vco_ff > VCO_MAX);

   // one restoring division step
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge    = trial >= {1'b0, pfd_ff};
   assign diff  = trial - {1'b0, pfd_ff};

   assign n_quo   = dvd_ff[TARGET_W-1:0];
   assign low_vco = vco_ff < VCO_DLY_EDGE;
   assign n_min   = low_vco ? N_MIN_LOW : N_MIN_HIGH;
   assign prod    = rem_ff * FRAC_DEN;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = (bad_range || (pfd_ff == '0)) ? S_HOLD : S_SCAN;
         end
         S_SCAN: begin
            priority if (scan_end) state_in = S_HOLD;
            else if (vco_ff >= VCO_MIN) state_in = S_DIVIDE;
            else state_in = S_SCAN;
         end
         S_DIVIDE: begin
            if (step_ff == STEP_W'(1)) state_in = frac_ff ? S_FINISH : S_EVAL;
         end
         S_EVAL: begin
            priority if (n_quo < n_min) state_in = S_SCAN;
            else if (n_quo > N_LIMIT) state_in = S_HOLD;
            else state_in = S_DIVIDE;
         end
         S_FINISH: state_in = S_HOLD;
         S_HOLD: begin
            if (!out_valid_ff || rsp_bus.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      pfd_in       = csr_wr ? pwdata[PFD_W-1:0] : pfd_ff;
      vco_in       = vco_ff;
      idx_in       = idx_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      frac_in      = frac_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      if (out_valid_ff && rsp_bus.ready) out_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               vco_in = VCO_W'(req_bus.target_freq_hz);
               idx_in = '0;
            end
         end
         S_CHECK: begin
            res_in = '0;
            priority if (bad_range) res_in.status = ST_RANGE;
            else if (pfd_ff == '0) res_in.status = ST_PFD_UNSET;
            else res_in.status = ST_NO_FIT;
         end
         S_SCAN: begin
            if (!scan_end) begin
               if (vco_ff >= VCO_MIN) begin
                  // quotient bits collect at the bottom as the dividend leaves the top
                  dvd_in  = {vco_ff[TARGET_W-1:0], (DVD_W - TARGET_W)'(0)};
                  rem_in  = '0;
                  step_in = STEPS_N;
                  frac_in = 1'b0;
               end else begin
                  vco_in = {vco_ff[VCO_W-2:0], 1'b0};
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         S_DIVIDE: begin
            dvd_in  = {dvd_ff[DVD_W-2:0], ge};
            rem_in  = ge ? diff[PFD_W-1:0] : trial[PFD_W-1:0];
            step_in = step_ff - STEP_W'(1);
         end
         S_EVAL: begin
            priority if (n_quo < n_min) begin
               vco_in = {vco_ff[VCO_W-2:0], 1'b0};
               idx_in = idx_ff + IW'(1);
            end else if (n_quo > N_LIMIT) begin
               res_in        = '0;
               res_in.status = ST_N_OVF;
            end else begin
               res_in.status           = ST_OK;
               res_in.divider_bypass   = (idx_ff == '0);
               res_in.divider_code     = div_code(4'(idx_ff));
               res_in.n_integer        = n_quo[18:0];
               res_in.n_numerator      = '0;
               res_in.pfd_delay_select = low_vco ? DLY_LOW : DLY_HIGH;
               dvd_in  = prod;
               rem_in  = '0;
               step_in = STEPS_FRAC;
               frac_in = 1'b1;
            end
         end
         S_FINISH: begin
            res_in.n_numerator = dvd_ff[19:0];
         end
         S_HOLD: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pfd_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pfd_ff       <= pfd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vco_ff  <= vco_in;
      idx_ff  <= idx_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      frac_ff <= frac_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.status           = out_ff.status;
   assign rsp_bus.divider_bypass   = out_ff.divider_bypass;
   assign rsp_bus.divider_code     = out_ff.divider_code;
   assign rsp_bus.n_integer        = out_ff.n_integer;
   assign rsp_bus.n_numerator      = out_ff.n_numerator;
   assign rsp_bus.pfd_delay_select = out_ff.pfd_delay_select;

endmodule

`default_nettype wire

>>> sv/fndp_checker.sv
`default_nettype none

module fndp_checker
   import fndp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  status,
   input wire logic        divider_bypass,
   input wire logic [3:0]  divider_code,
   input wire logic [18:0] n_integer,
   input wire logic [19:0] n_numerator,
   input wire logic [1:0]  pfd_delay_select
);

   // a stalled result beat keeps its valid and its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(n_integer)
         && $stable(n_numerator) && $stable(divider_code))
      else $error("result beat changed while stalled");

   // one item in flight: the port closes right after a beat is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a plan is in progress");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_OK) |-> !divider_bypass && (divider_code == 4'd0)
         && (n_integer == 19'd0) && (n_numerator == 20'd0) && (pfd_delay_select == 2'd0))
      else $error("failed plan carries non-zero fields");

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_OK) |->
         ((pfd_delay_select == DLY_LOW) || (pfd_delay_select == DLY_HIGH))
         && (n_numerator < FRAC_DEN) && (n_integer >= 19'd26)
         && (!divider_bypass || (divider_code == 4'd0)))
      else $error("inconsistent successful plan");

endmodule

bind fractional_n_divider_planner fndp_checker u_fndp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .status           (rsp_bus.status),
   .divider_bypass   (rsp_bus.divider_bypass),
   .divider_code     (rsp_bus.divider_code),
   .n_integer        (rsp_bus.n_integer),
   .n_numerator      (rsp_bus.n_numerator),
   .pfd_delay_select (rsp_bus.pfd_delay_select)
);

`default_nettype wire
